>>> sv/sag_pkg.sv
// Shared types and constants for the SAg two-level branch predictor.
// No dependencies; imported by sag_tab, the top level and its checker.
package sag_pkg;

	localparam int DEF_HIST_BITS  = 10;
	localparam int DEF_INDEX_BITS = 10;
	localparam int ADDR_W         = 64;

	// request codes
	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	localparam logic [1:0] CTR_MAX       = 2'd3;
	localparam logic [1:0] CTR_MIN       = 2'd0;
	localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;

	// memory strobes from the sequencer to the table block
	typedef struct packed {
		logic hist_rd;
		logic ctr_rd;
		logic upd_wr;
	} sag_mem_ctl_t;

	function automatic logic [1:0] ctr_step(input logic [1:0] ctr, input logic taken);
		logic [1:0] nxt;
		nxt = ctr;
		if (taken) begin
			if (ctr != CTR_MAX)
				nxt = ctr + 2'd1;
		end else begin
			if (ctr != CTR_MIN)
				nxt = ctr - 2'd1;
		end
		return nxt;
	endfunction

endpackage

>>> sv/sag_two_level_branch_predictor.sv
// Top level of the SAg two-level branch predictor: request sequencer, output register.
// Depends on sag_pkg and sag_tab.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------------
//  in      | in_valid / in_ready  | operation, branch_address, is_direct, branch_target,
//          |                      | was_taken
//  out     | out_valid / out_ready| predict_taken, predicted_target (predict only)
//
// Each request steps through history read, counter read, then counter/history
// write-back or result, in that order, since the two synchronous reads are chained.
// After reset both tables are swept to zero by a counter over the deeper table's
// addresses; in_ready stays low until the sweep is done.
// A predict waits in its last cycle while the output register is full and stalled;
// the output register lets the next request be taken while a result waits.
module sag_two_level_branch_predictor import sag_pkg::*; #(
	parameter int HIST_BITS  = DEF_HIST_BITS,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [ADDR_W-1:0] branch_address,
	input  logic              is_direct,
	input  logic [ADDR_W-1:0] branch_target,
	input  logic              was_taken,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              predict_taken,
	output logic [ADDR_W-1:0] predicted_target
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_HRD   = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic                  op_s1, direct_s1, taken_s1;
	logic [INDEX_BITS-1:0] slot_s1;
	logic [ADDR_W-1:0]     target_s1;
	logic [ADDR_W-1:0]     last_ind_q;
	logic                  out_valid_q, out_taken_q;
	logic [ADDR_W-1:0]     out_target_q;

	sag_mem_ctl_t          ctl;
	logic [INDEX_BITS-1:0] hist_addr;
	logic [HIST_BITS-1:0]  hist_rdata, hist_wdata;
	logic [HIST_BITS:0]    hist_shift;
	logic [1:0]            ctr_rdata, ctr_wdata;
	logic                  clear_done;
	logic                  accept, fin_go, emit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	// a predict may retire only when the output register can take it
	assign fin_go   = (state_q == ST_FIN) &&
	                  ((op_s1 == OP_UPDATE) || !out_valid_q || out_ready);
	assign emit     = fin_go && (op_s1 == OP_PREDICT);

	assign hist_addr  = (state_q == ST_IDLE) ? branch_address[INDEX_BITS-1:0] : slot_s1;
	assign hist_shift = {hist_rdata, taken_s1};
	assign hist_wdata = hist_shift[HIST_BITS-1:0];
	assign ctr_wdata  = ctr_step(ctr_rdata, taken_s1);

	always_comb begin
		ctl.hist_rd = accept;
		ctl.ctr_rd  = (state_q == ST_HRD);
		ctl.upd_wr  = fin_go && (op_s1 == OP_UPDATE);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_HRD;
			ST_HRD:   state_d = ST_FIN;
			ST_FIN:   if (fin_go) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			last_ind_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.upd_wr && !direct_s1)
				last_ind_q <= target_s1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			direct_s1 <= is_direct;
			taken_s1  <= was_taken;
			slot_s1   <= branch_address[INDEX_BITS-1:0];
			target_s1 <= branch_target;
		end
		if (emit) begin
			out_taken_q  <= (ctr_rdata >= CTR_TAKEN_MIN);
			out_target_q <= direct_s1 ? target_s1 : last_ind_q;
		end
	end

	sag_tab #(
		.HIST_BITS  (HIST_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_tab (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.hist_addr  (hist_addr),
		.hist_wdata (hist_wdata),
		.hist_rdata (hist_rdata),
		.ctr_addr   (hist_rdata),
		.ctr_wdata  (ctr_wdata),
		.ctr_rdata  (ctr_rdata),
		.clear_done (clear_done)
	);

	assign out_valid        = out_valid_q;
	assign predict_taken    = out_taken_q;
	assign predicted_target = out_target_q;

endmodule

>>> sv/sag_tab.sv
// History and counter memories of the SAg predictor, with the clearing sweep after reset.
// Depends on sag_pkg.
module sag_tab import sag_pkg::*; #(
	parameter int HIST_BITS  = DEF_HIST_BITS,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sag_mem_ctl_t          ctl,
	input  logic [INDEX_BITS-1:0] hist_addr,
	input  logic [HIST_BITS-1:0]  hist_wdata,
	output logic [HIST_BITS-1:0]  hist_rdata,
	input  logic [HIST_BITS-1:0]  ctr_addr,
	input  logic [1:0]            ctr_wdata,
	output logic [1:0]            ctr_rdata,
	output logic                  clear_done
);

	localparam int HIST_DEPTH = 1 << INDEX_BITS;
	localparam int CTR_DEPTH  = 1 << HIST_BITS;
	localparam int CLR_BITS   = (INDEX_BITS > HIST_BITS) ? INDEX_BITS : HIST_BITS;

	logic [HIST_BITS-1:0] hist_mem [HIST_DEPTH];
	logic [1:0]           ctr_mem  [CTR_DEPTH];

	logic [CLR_BITS-1:0]   clr_q;
	logic                  done_q;
	logic                  h_we, c_we;
	logic [INDEX_BITS-1:0] h_waddr;
	logic [HIST_BITS-1:0]  h_wdata_m;
	logic [HIST_BITS-1:0]  c_waddr;
	logic [1:0]            c_wdata_m;

	// sweep covers the deeper table; the shallower one is simply rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			clr_q <= clr_q + 1'b1;
			if (&clr_q)
				done_q <= 1'b1;
		end
	end

	always_comb begin
		if (!done_q) begin
			h_we      = 1'b1;
			c_we      = 1'b1;
			h_waddr   = clr_q[INDEX_BITS-1:0];
			c_waddr   = clr_q[HIST_BITS-1:0];
			h_wdata_m = '0;
			c_wdata_m = CTR_MIN;
		end else begin
			h_we      = ctl.upd_wr;
			c_we      = ctl.upd_wr;
			h_waddr   = hist_addr;
			c_waddr   = ctr_addr;
			h_wdata_m = hist_wdata;
			c_wdata_m = ctr_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (h_we)
			hist_mem[h_waddr] <= h_wdata_m;
		if (ctl.hist_rd)
			hist_rdata <= hist_mem[hist_addr];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			ctr_mem[c_waddr] <= c_wdata_m;
		if (ctl.ctr_rd)
			ctr_rdata <= ctr_mem[ctr_addr];
	end

	assign clear_done = done_q;

endmodule

>>> sv/sag_chk.sv
// Port-level checker for the SAg predictor, bound to the top level.
// Depends on sag_pkg and sag_two_level_branch_predictor.
module sag_chk import sag_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              operation,
	input logic              is_direct,
	input logic [ADDR_W-1:0] branch_target,
	input logic              out_valid,
	input logic              out_ready,
	input logic              predict_taken,
	input logic [ADDR_W-1:0] predicted_target
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(predict_taken) &&
		$stable(predicted_target))
		else $error("result changed while stalled");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// an update yields no result
	a_upd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_UPDATE) && !out_valid |=>
		!out_valid ##1 !out_valid ##1 !out_valid)
		else $error("update produced a result");

	// a direct predict taken while the output is empty returns its own target
	a_direct_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_PREDICT) && is_direct && !out_valid |->
		##3 out_valid && (predicted_target == $past(branch_target, 3)))
		else $error("direct predict target wrong or late");

endmodule

bind sag_two_level_branch_predictor sag_chk u_sag_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.operation        (operation),
	.is_direct        (is_direct),
	.branch_target    (branch_target),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.predict_taken    (predict_taken),
	.predicted_target (predicted_target)
);

>>> sim/sag_two_level_branch_predictor_tb.sv
// Self-checking testbench for the SAg two-level branch predictor.
// Depends on sag_pkg and sag_two_level_branch_predictor; a scoreboard class
// tracks history, counters and the indirect target and checks each prediction.
`timescale 1ns / 1ps

module sag_two_level_branch_predictor_tb import sag_pkg::*; ();

	localparam int HIST_BITS   = DEF_HIST_BITS;
	localparam int INDEX_BITS  = DEF_INDEX_BITS;
	localparam int HIST_DEPTH  = 1 << HIST_BITS;
	localparam int INDEX_DEPTH = 1 << INDEX_BITS;
	localparam int RANDOM_REQS = 1850;
	localparam int HOT_SLOTS   = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic              taken;
		logic [ADDR_W-1:0] target;
	} prediction_t;

	class prediction_scoreboard;
		logic [HIST_BITS-1:0] history_regs [INDEX_DEPTH];
		logic [1:0]           pattern_ctrs [HIST_DEPTH];
		logic [ADDR_W-1:0]    last_indirect;
		prediction_t          due_predictions [$];
		int                   failures;

		function new();
			foreach (history_regs[i])
				history_regs[i] = '0;
			foreach (pattern_ctrs[i])
				pattern_ctrs[i] = CTR_MIN;
			last_indirect = '0;
			failures = 0;
		endfunction

		function void note_request(input logic op, input logic [ADDR_W-1:0] addr,
				input logic direct, input logic [ADDR_W-1:0] target, input logic taken);
			logic [INDEX_BITS-1:0] slot;
			logic [HIST_BITS-1:0]  hist;
			logic [1:0]            ctr;
			prediction_t           pred;
			slot = addr[INDEX_BITS-1:0];
			hist = history_regs[slot];
			ctr  = pattern_ctrs[hist];
			if (op == OP_PREDICT) begin
				pred.taken  = (ctr >= CTR_TAKEN_MIN);
				pred.target = direct ? target : last_indirect;
				due_predictions.insert(due_predictions.size(), pred);
				return;
			end
			if (!direct)
				last_indirect = target;
			if (taken && ctr != CTR_MAX)
				ctr = ctr + 2'd1;
			else if (!taken && ctr != CTR_MIN)
				ctr = ctr - 2'd1;
			pattern_ctrs[hist] = ctr;
			history_regs[slot] = {hist[HIST_BITS-2:0], taken};
		endfunction

		function void check_prediction(input logic taken, input logic [ADDR_W-1:0] target);
			prediction_t exp_pred;
			if (due_predictions.size() == 0) begin
				$display("%0t: unexpected result: taken=%0b target=%h", $time, taken, target);
				failures++;
				return;
			end
			exp_pred = due_predictions.pop_front();
			if (taken !== exp_pred.taken) begin
				$display("%0t: predict_taken expected %0b actual %0b",
					$time, exp_pred.taken, taken);
				failures++;
			end
			if (target !== exp_pred.target) begin
				$display("%0t: predicted_target expected %h actual %h",
					$time, exp_pred.target, target);
				failures++;
			end
		endfunction

		function int pending();
			return due_predictions.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              operation;
	logic [ADDR_W-1:0] branch_address;
	logic              is_direct;
	logic [ADDR_W-1:0] branch_target;
	logic              was_taken;
	logic              out_valid;
	logic              out_ready;
	logic              predict_taken;
	logic [ADDR_W-1:0] predicted_target;

	prediction_scoreboard sb = new();
	bit                   quiet;
	int                   cycle_count = 0;
	logic [INDEX_BITS-1:0] hot_slot [HOT_SLOTS];
	int unsigned           hot_bias [HOT_SLOTS];

	sag_two_level_branch_predictor #(
		.HIST_BITS  (HIST_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.branch_address   (branch_address),
		.is_direct        (is_direct),
		.branch_target    (branch_target),
		.was_taken        (was_taken),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.predict_taken    (predict_taken),
		.predicted_target (predicted_target)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_idle();
		return quiet ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// valid is only lowered when a gap follows, so back-to-back requests keep it high
	task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
			input logic direct, input logic [ADDR_W-1:0] target, input logic taken);
		int gap;
		gap = draw_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		branch_address <= addr;
		is_direct      <= direct;
		branch_target  <= target;
		was_taken      <= taken;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
	endtask

	// mostly requests on a few hot slots with biased outcomes, so histories and
	// counters settle; the rest is unrelated noise
	task automatic send_random_request();
		int          k;
		logic        op;
		logic        taken;
		logic [ADDR_W-1:0] addr;
		k = $urandom_range(0, HOT_SLOTS - 1);
		op = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 80) begin
			addr = rand64();
			addr[INDEX_BITS-1:0] = hot_slot[k];
			taken = ($urandom_range(0, 99) < hot_bias[k]);
			send_request(op, addr, ($urandom_range(0, 9) < 7), rand64(), taken);
		end else begin
			send_request(op, rand64(), 1'($urandom_range(0, 1)), rand64(),
				1'($urandom_range(0, 1)));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_ready)
				sb.check_prediction(predict_taken, predicted_target);
			if (in_valid && in_ready === 1'b1)
				sb.note_request(operation, branch_address, is_direct, branch_target,
					was_taken);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: a random stall after each accepted result, ready held until the next
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_idle();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
		end
	end

	initial begin
		logic [ADDR_W-1:0] ind_a;
		quiet          = 1'b0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		operation      <= OP_PREDICT;
		branch_address <= '0;
		is_direct      <= 1'b0;
		branch_target  <= '0;
		was_taken      <= 1'b0;
		ind_a = 64'ha5a5_5a5a_0f0f_f0f0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// fresh state: counter 0 and indirect target still zero
		send_request(OP_PREDICT, 64'd0, 1'b0, '1, 1'b0);
		send_request(OP_PREDICT, '1, 1'b1, '1, 1'b1);
		// not taken at counter 0 must stay at 0
		send_request(OP_UPDATE, 64'd0, 1'b1, 64'd0, 1'b0);
		// four slots all at history 0 walk the same counter up and past saturation
		send_request(OP_UPDATE, 64'd1, 1'b1, '1, 1'b1);
		send_request(OP_UPDATE, 64'd2, 1'b1, 64'd0, 1'b1);
		send_request(OP_UPDATE, 64'd3, 1'b0, ind_a, 1'b1);
		send_request(OP_UPDATE, 64'd4, 1'b1, '1, 1'b1);
		send_request(OP_PREDICT, 64'd5, 1'b0, 64'd0, 1'b0);
		// upper address bits alias onto slot 1
		send_request(OP_PREDICT, {54'h3f_ffff_ffff_ffff, 10'd1}, 1'b1, ind_a, 1'b0);
		send_request(OP_UPDATE, {54'h2a_aaaa_aaaa_aaaa, 10'd1}, 1'b1, 64'd7, 1'b1);
		send_request(OP_PREDICT, 64'd1, 1'b0, '1, 1'b1);
		send_request(OP_UPDATE, 64'd6, 1'b0, 64'd0, 1'b0);
		send_request(OP_PREDICT, 64'd7, 1'b0, '1, 1'b0);
		send_request(OP_PREDICT, 64'hffff_ffff_ffff_fc00, 1'b1, 64'd0, 1'b1);
		send_request(OP_UPDATE, 64'h0000_0000_0000_03ff, 1'b0, '1, 1'b1);
		send_request(OP_PREDICT, 64'h8000_0000_0000_03ff, 1'b0, 64'd0, 1'b0);
		send_request(OP_UPDATE, '1, 1'b1, 64'h8000_0000_0000_0001, 1'b0);
		send_request(OP_PREDICT, '1, 1'b0, 64'h1, 1'b1);

		foreach (hot_slot[i]) begin
			hot_slot[i] = INDEX_BITS'($urandom);
			case ($urandom_range(0, 4))
				0: hot_bias[i] = 0;
				1: hot_bias[i] = 10;
				2: hot_bias[i] = 50;
				3: hot_bias[i] = 90;
				default: hot_bias[i] = 100;
			endcase
		end
		for (int i = 0; i < RANDOM_REQS; i++) begin
			quiet = ((i / 150) % 3 == 1);
			send_random_request();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// let any stray result turn up
		repeat (12) @(posedge clk);
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
sv/sag_pkg.sv
sv/sag_tab.sv
sv/sag_two_level_branch_predictor.sv
sv/sag_chk.sv
sim/sag_two_level_branch_predictor_tb.sv
